@@ design/hbk_pkg.sv @@
// ----------------------------------------------------------------------------
// hbk_pkg: shared types and tables for the boot keyboard report differ
// Holds the report and job formats, the event format and the key code ROMs.
// ----------------------------------------------------------------------------
package hbk_pkg;

   // usage codes carried by one boot report
   localparam int MAX_KEYS    = 6;
   // candidate event slots per job: modifier bits, then presses, then releases
   localparam int MOD_BITS    = 8;
   localparam int SLOT_COUNT  = MOD_BITS + 2 * MAX_KEYS;
   localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
   localparam int PRESS_BASE  = MOD_BITS;
   localparam int REL_BASE    = MOD_BITS + MAX_KEYS;

   typedef struct packed {
      logic                          slot_is_keyboard;
      logic [7:0]                    modifier_bits;
      logic [MAX_KEYS-1:0][7:0]      key_codes;
   } report_type;

   typedef struct packed {
      logic [3:0]                    mods;
      logic [SLOT_COUNT-1:0]         mask;
      logic [SLOT_COUNT-1:0]         pressed;
      logic [SLOT_COUNT-1:0][7:0]    keys;
   } job_type;

   typedef struct packed {
      logic [7:0]                    event_key;
      logic                          event_pressed;
      logic [3:0]                    event_mods;
      logic                          event_last;
   } event_type;

   // fold the modifier byte: ctrl, shift, alt from either side, left gui as caps
   function automatic logic [3:0] fold_mods(input logic [7:0] m);
      fold_mods = {m[3], m[2] | m[6], m[1] | m[5], m[0] | m[4]};
   endfunction

   // key numbers for modifier bits, gui bits give zero
   function automatic logic [7:0] mod_key(input logic [2:0] bit_idx);
      logic [7:0] k;
      unique case (bit_idx)
         3'd0:    k = 8'd29;
         3'd1:    k = 8'd42;
         3'd2:    k = 8'd56;
         3'd3:    k = 8'd0;
         3'd4:    k = 8'd97;
         3'd5:    k = 8'd54;
         3'd6:    k = 8'd100;
         default: k = 8'd0;
      endcase
      return k;
   endfunction

   // hid usage code to key number, zero when unmapped
   function automatic logic [7:0] usage_key(input logic [7:0] code);
      logic [7:0] k;
      unique case (code)
         8'h04: k = 8'd30;   8'h05: k = 8'd48;   8'h06: k = 8'd46;   8'h07: k = 8'd32;
         8'h08: k = 8'd18;   8'h09: k = 8'd33;   8'h0A: k = 8'd34;   8'h0B: k = 8'd35;
         8'h0C: k = 8'd23;   8'h0D: k = 8'd36;   8'h0E: k = 8'd37;   8'h0F: k = 8'd38;
         8'h10: k = 8'd50;   8'h11: k = 8'd49;   8'h12: k = 8'd24;   8'h13: k = 8'd25;
         8'h14: k = 8'd16;   8'h15: k = 8'd19;   8'h16: k = 8'd31;   8'h17: k = 8'd20;
         8'h18: k = 8'd22;   8'h19: k = 8'd47;   8'h1A: k = 8'd17;   8'h1B: k = 8'd45;
         8'h1C: k = 8'd21;   8'h1D: k = 8'd44;   8'h1E: k = 8'd2;    8'h1F: k = 8'd3;
         8'h20: k = 8'd4;    8'h21: k = 8'd5;    8'h22: k = 8'd6;    8'h23: k = 8'd7;
         8'h24: k = 8'd8;    8'h25: k = 8'd9;    8'h26: k = 8'd10;   8'h27: k = 8'd11;
         8'h28: k = 8'd28;   8'h29: k = 8'd1;    8'h2A: k = 8'd14;   8'h2B: k = 8'd15;
         8'h2C: k = 8'd57;   8'h2D: k = 8'd12;   8'h2E: k = 8'd13;   8'h2F: k = 8'd26;
         8'h30: k = 8'd27;   8'h31: k = 8'd43;   8'h33: k = 8'd39;   8'h34: k = 8'd40;
         8'h35: k = 8'd41;   8'h36: k = 8'd51;   8'h37: k = 8'd52;   8'h38: k = 8'd53;
         8'h39: k = 8'd58;   8'h3A: k = 8'd59;   8'h3B: k = 8'd60;   8'h3C: k = 8'd61;
         8'h3D: k = 8'd62;   8'h3E: k = 8'd63;   8'h3F: k = 8'd64;   8'h40: k = 8'd65;
         8'h41: k = 8'd66;   8'h42: k = 8'd67;   8'h43: k = 8'd68;   8'h44: k = 8'd87;
         8'h45: k = 8'd88;   8'h49: k = 8'd110;  8'h4A: k = 8'd102;  8'h4B: k = 8'd104;
         8'h4C: k = 8'd111;  8'h4D: k = 8'd107;  8'h4E: k = 8'd109;  8'h4F: k = 8'd106;
         8'h50: k = 8'd105;  8'h51: k = 8'd108;  8'h52: k = 8'd103;
         default: k = 8'd0;
      endcase
      return k;
   endfunction

endpackage

@@ design/hbk_req_if.sv @@
// ----------------------------------------------------------------------------
// hbk_req_if: report channel
// Valid/ready channel carrying one boot keyboard report per transfer.
// ----------------------------------------------------------------------------
interface hbk_req_if;
   logic       valid;
   logic       ready;
   logic       slot_is_keyboard;
   logic [7:0] modifier_bits;
   logic [7:0] key_code_0;
   logic [7:0] key_code_1;
   logic [7:0] key_code_2;
   logic [7:0] key_code_3;
   logic [7:0] key_code_4;
   logic [7:0] key_code_5;

   modport source (output valid, slot_is_keyboard, modifier_bits, key_code_0, key_code_1,
                   key_code_2, key_code_3, key_code_4, key_code_5, input ready);
   modport sink   (input valid, slot_is_keyboard, modifier_bits, key_code_0, key_code_1,
                   key_code_2, key_code_3, key_code_4, key_code_5, output ready);
endinterface

@@ design/hbk_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hbk_rsp_if: key event channel
// Valid/ready channel carrying one key event per transfer.
// ----------------------------------------------------------------------------
interface hbk_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] event_key;
   logic       event_pressed;
   logic [3:0] event_mods;
   logic       event_last;

   modport source (output valid, event_key, event_pressed, event_mods, event_last,
                   input ready);
   modport sink   (input valid, event_key, event_pressed, event_mods, event_last,
                   output ready);
endinterface

@@ design/hbk_front.sv @@
// ----------------------------------------------------------------------------
// hbk_front: report intake and classification
// Compares each keyboard report with the stored one and builds a job holding
// every candidate event slot with its valid bit, key number and direction.
// ----------------------------------------------------------------------------
module hbk_front #(
   parameter int KEYS_PER_REPORT = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  hbk_pkg::report_type report,
   input  logic               queue_full,
   output logic               push,
   output hbk_pkg::job_type   job
);
   import hbk_pkg::*;

   logic [7:0] prev_mods_ff;
   logic [7:0] prev_mods_in;
   logic [7:0] prev_keys_ff [KEYS_PER_REPORT];
   logic [7:0] prev_keys_in [KEYS_PER_REPORT];
   logic       accept;
   logic       update;
   logic [7:0] diff;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign update    = accept && report.slot_is_keyboard;
   assign diff      = report.modifier_bits ^ prev_mods_ff;

   // candidate slots for modifier changes, presses and releases
   always_comb begin
      logic in_old;
      logic in_cur;
      job = '0;
      job.mods = fold_mods(report.modifier_bits);
      for (int b = 0; b < MOD_BITS; b++) begin
         job.mask[b]    = diff[b];
         job.pressed[b] = report.modifier_bits[b];
         job.keys[b]    = mod_key(3'(b));
      end
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         in_old = 1'b0;
         in_cur = 1'b0;
         for (int j = 0; j < KEYS_PER_REPORT; j++) begin
            in_old = in_old | (prev_keys_ff[j] == report.key_codes[i]);
            in_cur = in_cur | (report.key_codes[j] == prev_keys_ff[i]);
         end
         job.keys[PRESS_BASE + i]    = usage_key(report.key_codes[i]);
         job.pressed[PRESS_BASE + i] = 1'b1;
         job.mask[PRESS_BASE + i]    = (report.key_codes[i] != 8'd0) && !in_old
                                       && (job.keys[PRESS_BASE + i] != 8'd0);
         job.keys[REL_BASE + i]      = usage_key(prev_keys_ff[i]);
         job.pressed[REL_BASE + i]   = 1'b0;
         job.mask[REL_BASE + i]      = (prev_keys_ff[i] != 8'd0) && !in_cur
                                       && (job.keys[REL_BASE + i] != 8'd0);
      end
   end

   // reports with no event leave nothing for the back end
   assign push = update && (job.mask != '0);

   // stored report follows each keyboard transfer
   always_comb begin
      prev_mods_in = prev_mods_ff;
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         prev_keys_in[i] = prev_keys_ff[i];
      end
      if (update) begin
         prev_mods_in = report.modifier_bits;
         for (int i = 0; i < KEYS_PER_REPORT; i++) begin
            prev_keys_in[i] = report.key_codes[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mods_ff <= '0;
         for (int i = 0; i < KEYS_PER_REPORT; i++) begin
            prev_keys_ff[i] <= '0;
         end
      end else begin
         prev_mods_ff <= prev_mods_in;
         for (int i = 0; i < KEYS_PER_REPORT; i++) begin
            prev_keys_ff[i] <= prev_keys_in[i];
         end
      end
   end

endmodule

@@ design/hbk_job_queue.sv @@
// ----------------------------------------------------------------------------
// hbk_job_queue: two-entry job queue
// Decouples report intake from event emission.
// ----------------------------------------------------------------------------
module hbk_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hbk_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output hbk_pkg::job_type head
);
   import hbk_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/hbk_back.sv @@
// ----------------------------------------------------------------------------
// hbk_back: event emitter
// Takes one job at a time and sends its valid slots in slot order through an
// output register, one event per cycle if not stalled, to the per-report cap.
// ----------------------------------------------------------------------------
module hbk_back #(
   parameter int EVENT_QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  hbk_pkg::job_type   job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hbk_pkg::event_type rsp_event
);
   import hbk_pkg::*;

   localparam int CW = $clog2(EVENT_QUEUE_DEPTH);
   localparam logic [CW-1:0] LAST_COUNT = CW'(EVENT_QUEUE_DEPTH - 2);

   job_type               cur_ff;
   job_type               cur_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   event_type             rsp_event_ff;
   event_type             rsp_event_in;
   logic [SLOT_COUNT-1:0] low_bit;
   logic [SLOT_COUNT-1:0] remaining;
   logic [SLOT_IDX_W-1:0] idx;
   logic                  out_free;
   logic                  emit;
   logic                  last;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign pop      = !busy_ff && job_valid;

   // next slot to send
   always_comb begin
      low_bit   = cur_ff.mask & (~cur_ff.mask + 1'b1);
      remaining = cur_ff.mask & ~low_bit;
      idx       = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (low_bit[s]) begin
            idx = idx | SLOT_IDX_W'(s);
         end
      end
      last = (remaining == '0) || (count_ff == LAST_COUNT);
   end

   // job load and slot walk
   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         cur_in   = job;
         busy_in  = 1'b1;
         count_in = '0;
      end
      if (emit) begin
         cur_in.mask                = remaining;
         count_in                   = count_ff + 1'b1;
         busy_in                    = !last;
         rsp_valid_in               = 1'b1;
         rsp_event_in.event_key     = cur_ff.keys[idx];
         rsp_event_in.event_pressed = cur_ff.pressed[idx];
         rsp_event_in.event_mods    = cur_ff.mods;
         rsp_event_in.event_last    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rsp_event_ff <= rsp_event_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event = rsp_event_ff;

endmodule

@@ design/hid_boot_report_key_events.sv @@
// The first event of a report passes through the job queue, the emitter's job
// register and the output register. Events leave one per cycle while the
// output is free; each report takes one job load, then one slot per event.
// Reports are taken every cycle while the two-entry job queue has room.
// Reset (synchronous, active high) clears the stored report to zero and
// empties the queue and the output register.
// ----------------------------------------------------------------------------
// hid_boot_report_key_events: boot keyboard report differ
// Turns successive boot keyboard reports into ordered press/release events.
// ----------------------------------------------------------------------------
module hid_boot_report_key_events #(
   parameter int KEYS_PER_REPORT   = 6,
   parameter int EVENT_QUEUE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   hbk_req_if.sink   req_chan,
   hbk_rsp_if.source rsp_chan
);
   import hbk_pkg::*;

   report_type report;
   job_type    front_job;
   job_type    head_job;
   event_type  rsp_event;
   logic       push;
   logic       pop;
   logic       queue_full;
   logic       queue_empty;

   // gather the report fields
   assign report.slot_is_keyboard = req_chan.slot_is_keyboard;
   assign report.modifier_bits    = req_chan.modifier_bits;
   assign report.key_codes[0]     = req_chan.key_code_0;
   assign report.key_codes[1]     = req_chan.key_code_1;
   assign report.key_codes[2]     = req_chan.key_code_2;
   assign report.key_codes[3]     = req_chan.key_code_3;
   assign report.key_codes[4]     = req_chan.key_code_4;
   assign report.key_codes[5]     = req_chan.key_code_5;

   hbk_front #(
      .KEYS_PER_REPORT (KEYS_PER_REPORT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .report     (report),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   hbk_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head_job)
   );

   hbk_back #(
      .EVENT_QUEUE_DEPTH (EVENT_QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!queue_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_event (rsp_event)
   );

   // event fields
   assign rsp_chan.event_key     = rsp_event.event_key;
   assign rsp_chan.event_pressed = rsp_event.event_pressed;
   assign rsp_chan.event_mods    = rsp_event.event_mods;
   assign rsp_chan.event_last    = rsp_event.event_last;

   // a job is never written into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("job pushed into full queue");

   // non-keyboard reports never create a job
   a_ignore_other_slots: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.slot_is_keyboard) |-> !push)
      else $error("job created for non-keyboard report");

   // reset leaves the queue empty and no event pending
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (queue_empty && !rsp_chan.valid))
      else $error("queue or output not cleared by reset");

endmodule
